@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define SD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Default form: clk_i and rst_ni of the enclosing module
`define SD_ASSERT_DEF(lbl, prop, msg) \
  `SD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/stdef_pkg.sv @@
// ----------------------------------------------------------------------------
// stdef_pkg
// Types and constants of the serial telegram deframer.
// ----------------------------------------------------------------------------
package stdef_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  // Frame phases, also the reported frame_state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RECV  = 2'd1,
    PH_DONE  = 2'd2,
    PH_ERROR = 2'd3
  } phase_e;

  localparam int unsigned CNT_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SHORT_W = 6;

  localparam logic [CNT_W-1:0]  MAX_TELEGRAM   = 9'd260;
  localparam logic [CNT_W-1:0]  SHORT_OVERHEAD = 9'd4;
  localparam logic [CNT_W-1:0]  LONG_OVERHEAD  = 9'd5;
  localparam logic [CNT_W-1:0]  MIN_COMPLETE   = 9'd4;
  localparam logic [CNT_W-1:0]  LONG_LEN_POS   = 9'd3;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET  = 8'd3;

  // One request as held in the input register
  typedef struct packed {
    mode_e             mode;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // One result as held in the output register
  typedef struct packed {
    phase_e            frame_state;
    logic              store_valid;
    logic [CNT_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic [CNT_W-1:0]  telegram_length;
    logic              released;
    logic              checksum_error;
  } result_t;

endpackage

@@ hdl/stdef_if.sv @@
// ----------------------------------------------------------------------------
// stdef_if
// Valid/ready channels of the deframer: request channel and result channel.
// ----------------------------------------------------------------------------
interface stdef_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface stdef_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_state;
  logic       store_valid;
  logic [8:0] store_index;
  logic [7:0] store_byte;
  logic [8:0] telegram_length;
  logic       released;
  logic       checksum_error;

  modport source (
    output valid, output frame_state, output store_valid, output store_index,
    output store_byte, output telegram_length, output released,
    output checksum_error, input ready
  );
  modport sink (
    input valid, input frame_state, input store_valid, input store_index,
    input store_byte, input telegram_length, input released,
    input checksum_error, output ready
  );
endinterface

@@ hdl/stdef_in_stage.sv @@
// ----------------------------------------------------------------------------
// stdef_in_stage
// Input register: captures one request and holds it until the frame logic
// moves it on.
// ----------------------------------------------------------------------------
module stdef_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          rx_byte_i,
  output logic                ready_o,
  input  logic                advance_i,
  output logic                item_valid_o,
  output stdef_pkg::item_t    item_o
);
  import stdef_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  // Free slot, or the held request leaves this cycle
  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{mode: mode_e'(mode_i), rx_byte: rx_byte_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ hdl/stdef_core.sv @@
// ----------------------------------------------------------------------------
// stdef_core
// Frame state, timeout counter and timeout register, with the single-pass
// logic that turns one request into the next state and its result.
// ----------------------------------------------------------------------------
module stdef_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 advance_i,
  input  stdef_pkg::item_t     item_i,
  output stdef_pkg::result_t   result_o
);
  import stdef_pkg::*;

  // State
  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BYTE_W-1:0]  sum_q, sum_d;
  logic [SHORT_W-1:0] short_q, short_d;
  logic [BYTE_W-1:0]  long_q, long_d;
  logic [BYTE_W-1:0]  left_q, left_d;
  logic [BYTE_W-1:0]  timeout_q;

  // Helpers for a byte in the receiving phase
  logic               room;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_new;
  logic [BYTE_W-1:0]  long_new;
  logic [CNT_W-1:0]   exp_len;
  logic               complete;
  logic [BYTE_W-1:0]  b;

  result_t res;

  assign b        = item_i.rx_byte;
  assign room     = count_q < MAX_TELEGRAM;
  assign cnt_inc  = count_q + 9'd1;
  assign cnt_new  = room ? cnt_inc : count_q;
  // Fourth byte carries the extended length
  assign long_new = (room && count_q == LONG_LEN_POS) ? b : long_q;
  assign exp_len  = (short_q == '0) ? ({1'b0, long_new} + LONG_OVERHEAD)
                                    : ({3'b000, short_q} + SHORT_OVERHEAD);
  assign complete = (cnt_new >= MIN_COMPLETE) && (cnt_new >= exp_len);

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    short_d = short_q;
    long_d  = long_q;
    left_d  = left_q;
    res     = '0;

    case (item_i.mode)
      MODE_BYTE: begin
        left_d = timeout_q;
        case (phase_q)
          PH_IDLE: begin
            count_d         = 9'd1;
            sum_d           = b;
            short_d         = b[SHORT_W-1:0];
            long_d          = '0;
            phase_d         = PH_RECV;
            res.store_valid = 1'b1;
            res.store_byte  = b;
          end
          PH_RECV: begin
            if (room) begin
              res.store_valid = 1'b1;
              res.store_index = count_q;
              res.store_byte  = b;
              long_d          = long_new;
              count_d         = cnt_inc;
            end
            if (complete) begin
              if (sum_q != b) begin
                phase_d            = PH_ERROR;
                res.checksum_error = 1'b1;
              end else begin
                left_d  = '0;
                phase_d = PH_DONE;
              end
            end else begin
              sum_d = sum_q + b;
            end
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        if (left_q != '0) begin
          left_d = left_q - 8'd1;
          // Timer runs out: drop an unfinished or failed telegram
          if (left_q == 8'd1 && (phase_q == PH_RECV || phase_q == PH_ERROR)) begin
            phase_d = PH_IDLE;
          end
        end
      end
      MODE_RELEASE: begin
        if (phase_q == PH_DONE) begin
          res.released        = 1'b1;
          res.telegram_length = count_q;
          phase_d             = PH_IDLE;
        end
      end
      default: ;
    endcase

    if (phase_d == PH_DONE) begin
      res.telegram_length = count_d;
    end
    res.frame_state = phase_d;
  end

  assign result_o = res;

  // State registers, updated when the request moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      short_q <= '0;
      long_q  <= '0;
      left_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      short_q <= short_d;
      long_q  <= long_d;
      left_q  <= left_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

endmodule

@@ hdl/stdef_out_stage.sv @@
// ----------------------------------------------------------------------------
// stdef_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module stdef_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  stdef_pkg::result_t   result_i,
  input  logic                 ready_i,
  output logic                 can_load_o,
  output logic                 valid_o,
  output stdef_pkg::result_t   result_o
);
  import stdef_pkg::*;

  logic    valid_q;
  result_t result_q;

  // Empty, or the held result is taken this cycle
  assign can_load_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ hdl/serial_telegram_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// serial_telegram_deframer_unit
// Deframes diagnostic telegrams from a serial byte stream and streams the
// accepted bytes out with their index.
// ----------------------------------------------------------------------------
// Each request (received byte, millisecond tick or host release) yields
// exactly one result. A request is accepted in every cycle as long as the
// result side keeps up. An accepted request is held in the input register;
// the frame logic then updates it in a single pass into the result register
// once that register has room, and the result is held there until taken.
// When the result register is full and not taken, one more request is held
// in the input register before ready drops. The byte timeout register resets
// to 3 ticks; the user must write it only while no request is in flight, as
// the block itself does not enforce this. A value of zero disables the
// timeout.
module serial_telegram_deframer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  stdef_in_if.sink          req_i,
  stdef_out_if.source       res_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import stdef_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    can_load;
  logic    advance;
  result_t result_d;
  result_t result_q;
  logic    res_valid;

  // Request moves on when the result register has room
  assign advance = item_valid && can_load;

  stdef_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (req_i.valid),
    .mode_i       (req_i.mode),
    .rx_byte_i    (req_i.rx_byte),
    .ready_o      (req_i.ready),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  stdef_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (item),
    .result_o    (result_d)
  );

  stdef_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (result_d),
    .ready_i    (res_o.ready),
    .can_load_o (can_load),
    .valid_o    (res_valid),
    .result_o   (result_q)
  );

  // Result channel
  assign res_o.valid           = res_valid;
  assign res_o.frame_state     = result_q.frame_state;
  assign res_o.store_valid     = result_q.store_valid;
  assign res_o.store_index     = result_q.store_index;
  assign res_o.store_byte      = result_q.store_byte;
  assign res_o.telegram_length = result_q.telegram_length;
  assign res_o.released        = result_q.released;
  assign res_o.checksum_error  = result_q.checksum_error;

endmodule

@@ hdl/stdef_checker.sv @@
// ----------------------------------------------------------------------------
// stdef_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stdef_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] frame_state_i,
  input logic       store_valid_i,
  input logic [8:0] telegram_length_i,
  input logic       released_i,
  input logic       checksum_error_i
);
  import stdef_pkg::*;

  // A stored byte always leaves a telegram open, finished or failed
  `SD_ASSERT_DEF(a_store_not_idle, out_valid_i && store_valid_i |-> frame_state_i != PH_IDLE, "byte stored but frame idle")

  // A release hands over a nonempty telegram and frees the deframer
  `SD_ASSERT_DEF(a_release_idle, out_valid_i && released_i |-> frame_state_i == PH_IDLE && telegram_length_i != '0, "bad release result")

  // A checksum mismatch happens on a stored final byte
  `SD_ASSERT_DEF(a_cerr_state, out_valid_i && checksum_error_i |-> frame_state_i == PH_ERROR && store_valid_i, "bad checksum error result")

  // Length is reported only for a finished or released telegram
  `SD_ASSERT_DEF(a_len_only_done, out_valid_i && telegram_length_i != '0 |-> frame_state_i == PH_DONE || released_i, "stray telegram length")

  // A stalled result holds
  `SD_ASSERT_DEF(a_res_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(telegram_length_i), "stalled result changed")

endmodule

bind serial_telegram_deframer_unit stdef_checker u_stdef_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .frame_state_i     (res_o.frame_state),
  .store_valid_i     (res_o.store_valid),
  .telegram_length_i (res_o.telegram_length),
  .released_i        (res_o.released),
  .checksum_error_i  (res_o.checksum_error)
);

@@ bench/serial_telegram_deframer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_telegram_deframer_checker
// Watches the request, result and timeout-register ports of the deframer.
// It keeps its own copy of the frame state, works out the result of every
// accepted request and compares the results, in order, field by field.
// ----------------------------------------------------------------------------
module serial_telegram_deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  stdef_in_if         req_i,
  stdef_out_if        res_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);
  import stdef_pkg::*;

  // Shadow of the frame state
  phase_e             frame_phase;
  logic [CNT_W-1:0]   rx_count;
  logic [BYTE_W-1:0]  sum_q;
  logic [SHORT_W-1:0] short_len;
  logic [BYTE_W-1:0]  long_len;
  logic [BYTE_W-1:0]  ticks_left;
  logic [BYTE_W-1:0]  timeout_cfg;

  result_t expected_q[$];

  // Advance the shadow state by one request and build its result
  task automatic deframe_step(input mode_e m, input logic [7:0] b, output result_t r);
    logic [CNT_W-1:0] need_len;
    r = '0;
    case (m)
      MODE_BYTE: begin
        ticks_left = timeout_cfg;
        if (frame_phase == PH_IDLE) begin
          rx_count      = 9'd1;
          sum_q         = b;
          short_len     = b[SHORT_W-1:0];
          long_len      = '0;
          frame_phase   = PH_RECV;
          r.store_valid = 1'b1;
          r.store_index = '0;
          r.store_byte  = b;
        end else if (frame_phase == PH_RECV) begin
          if (rx_count < MAX_TELEGRAM) begin
            r.store_valid = 1'b1;
            r.store_index = rx_count;
            r.store_byte  = b;
            if (rx_count == LONG_LEN_POS) long_len = b;
            rx_count = rx_count + 9'd1;
          end
          need_len = (short_len == '0) ? {1'b0, long_len} + LONG_OVERHEAD
                                       : {3'b000, short_len} + SHORT_OVERHEAD;
          // last byte carries the checksum of everything before it
          if (rx_count >= MIN_COMPLETE && rx_count >= need_len) begin
            if (sum_q != b) begin
              frame_phase      = PH_ERROR;
              r.checksum_error = 1'b1;
            end else begin
              ticks_left  = '0;
              frame_phase = PH_DONE;
            end
          end else begin
            sum_q = sum_q + b;
          end
        end
      end
      MODE_TICK: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - 8'd1;
          if (ticks_left == '0 && (frame_phase == PH_RECV || frame_phase == PH_ERROR))
            frame_phase = PH_IDLE;
        end
      end
      MODE_RELEASE: begin
        if (frame_phase == PH_DONE) begin
          r.released        = 1'b1;
          r.telegram_length = rx_count;
          frame_phase       = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (frame_phase == PH_DONE) r.telegram_length = rx_count;
    r.frame_state = frame_phase;
  endtask

  // Compare on result handshake, update register copy, predict on request
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t exp_res;
    result_t nxt;
    if (!rst_ni) begin
      frame_phase    = PH_IDLE;
      rx_count       = '0;
      sum_q          = '0;
      short_len      = '0;
      long_len       = '0;
      ticks_left     = '0;
      timeout_cfg    = TIMEOUT_RESET;
      expected_q.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.frame_state     = phase_e'(res_i.frame_state);
        got.store_valid     = res_i.store_valid;
        got.store_index     = res_i.store_index;
        got.store_byte      = res_i.store_byte;
        got.telegram_length = res_i.telegram_length;
        got.released        = res_i.released;
        got.checksum_error  = res_i.checksum_error;
        if (expected_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%0t: result with no request pending: state=%0d sv=%0b idx=%0d",
                     $time, got.frame_state, got.store_valid, got.store_index);
        end else begin
          exp_res = expected_q.pop_front();
          if (got.frame_state     !== exp_res.frame_state     ||
              got.store_valid     !== exp_res.store_valid     ||
              got.store_index     !== exp_res.store_index     ||
              got.store_byte      !== exp_res.store_byte      ||
              got.telegram_length !== exp_res.telegram_length ||
              got.released        !== exp_res.released        ||
              got.checksum_error  !== exp_res.checksum_error) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display({"%0t: mismatch, expected state=%0d sv=%0b idx=%0d byte=%02h",
                        " len=%0d rel=%0b cerr=%0b"},
                       $time, exp_res.frame_state, exp_res.store_valid, exp_res.store_index,
                       exp_res.store_byte, exp_res.telegram_length, exp_res.released,
                       exp_res.checksum_error);
              $display({"%0t:           actual   state=%0d sv=%0b idx=%0d byte=%02h",
                        " len=%0d rel=%0b cerr=%0b"},
                       $time, got.frame_state, got.store_valid, got.store_index,
                       got.store_byte, got.telegram_length, got.released, got.checksum_error);
            end
          end
        end
      end
      if (cfg_we_i) timeout_cfg = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        deframe_step(mode_e'(req_i.mode), req_i.rx_byte, nxt);
        expected_q.push_back(nxt);
      end
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

@@ bench/serial_telegram_deframer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_telegram_deframer_unit_tb
// Drives byte, tick and release requests into the deframer: a few directed
// telegrams first, then random well-formed, corrupted and cut-off telegrams
// mixed with noise, under several idle/stall patterns and timeout settings.
// Results are checked by the checker instance beside the block.
// ----------------------------------------------------------------------------
module serial_telegram_deframer_unit_tb;
  import stdef_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned req_cnt;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned timeout_ticks;

  logic [7:0] frame_q[$];

  stdef_in_if  req_if ();
  stdef_out_if res_if ();

  serial_telegram_deframer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  serial_telegram_deframer_checker i_frame_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side backpressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[serial_telegram_deframer_unit] ERROR");
      $finish;
    end
  end

  // One request, with random gaps before it; returns after acceptance
  task automatic send_req(input mode_e m, input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.rx_byte <= b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    req_cnt++;
  endtask

  // Fill frame_q with a telegram; short form when ext is 0
  task automatic build_frame(input bit ext, input int dlen, input bit corrupt);
    logic [7:0] sum;
    frame_q.delete();
    if (ext) frame_q.push_back({2'($urandom), 6'd0});
    else     frame_q.push_back({2'($urandom), 6'(dlen)});
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    if (ext) frame_q.push_back(8'(dlen));
    repeat (dlen) frame_q.push_back(8'($urandom));
    sum = '0;
    foreach (frame_q[k]) sum = sum + frame_q[k];
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
  endtask

  task automatic send_range(input int lo, input int hi);
    for (int k = lo; k < hi; k++) send_req(MODE_BYTE, frame_q[k]);
  endtask

  // Mostly small telegrams, now and then the largest of each form
  task automatic build_random_frame(input bit corrupt);
    bit ext;
    int dlen;
    ext = 1'($urandom_range(1));
    if ($urandom_range(99) < 5) dlen = ext ? 255 : 63;
    else                        dlen = ext ? $urandom_range(0, 12) : $urandom_range(1, 12);
    build_frame(ext, dlen, corrupt);
  endtask

  // Enough ticks to drop any open telegram, then a release for a done one
  task automatic flush_frame();
    repeat (timeout_ticks) send_req(MODE_TICK, 8'($urandom));
    send_req(MODE_RELEASE, 8'($urandom));
  endtask

  // Let every request in flight come out
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    timeout_ticks = 32'(v);
  endtask

  // Random traffic until req_cnt reaches stop_at; without faults the frame
  // state always returns to idle through a release
  task automatic random_traffic(input int unsigned stop_at, input bit faults);
    int unsigned r;
    bit bad;
    while (req_cnt < stop_at) begin
      r = $urandom_range(99);
      if (!faults || r < 60) begin
        bad = faults && ($urandom_range(99) < 15);
        build_random_frame(bad);
        send_range(0, frame_q.size());
        // noise while done or in error
        repeat ($urandom_range(0, 2))
          send_req(mode_e'(faults ? $urandom_range(0, 3) : $urandom_range(1, 3)),
                   8'($urandom));
        if (bad) flush_frame();
        else     send_req(MODE_RELEASE, 8'($urandom));
      end else if (r < 80) begin
        build_random_frame(1'($urandom_range(1)));
        send_range(0, $urandom_range(1, frame_q.size() - 1));
        flush_frame();
      end else begin
        repeat ($urandom_range(1, 4))
          send_req(mode_e'($urandom_range(0, 3)), 8'($urandom));
        flush_frame();
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_NONE;
    req_if.rx_byte = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    req_cnt        = 0;
    timeout_ticks  = 32'(TIMEOUT_RESET);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Good short telegram; tick and byte while done; release twice; no-op
    build_frame(1'b0, 1, 1'b0);
    send_range(0, frame_q.size());
    send_req(MODE_TICK, 8'h00);
    send_req(MODE_BYTE, 8'hFF);
    send_req(MODE_RELEASE, 8'h00);
    send_req(MODE_RELEASE, 8'hFF);
    send_req(MODE_TICK, 8'h55);
    send_req(MODE_NONE, 8'hFF);
    // Extended form with zero data bytes
    build_frame(1'b1, 0, 1'b0);
    send_range(0, frame_q.size());
    send_req(MODE_RELEASE, 8'hAA);
    // Bad checksum, byte ignored in error, timeout back to idle
    build_frame(1'b0, 1, 1'b1);
    send_range(0, frame_q.size());
    send_req(MODE_BYTE, 8'h00);
    repeat (3) send_req(MODE_TICK, 8'h00);
    // Cut-off telegram dropped by timeout
    build_frame(1'b0, 3, 1'b0);
    send_range(0, 2);
    repeat (3) send_req(MODE_TICK, 8'hFF);

    // Random part over the idling patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 70; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 70; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      case (p)
        0:       write_timeout(8'd1);
        1:       write_timeout(8'd4);
        2:       write_timeout(8'($urandom_range(2, 10)));
        default: write_timeout(8'd1);
      endcase
      random_traffic(req_cnt + 40, 1'b1);
    end

    // Timeout disabled: an open telegram survives any number of ticks
    write_timeout(8'd0);
    build_frame(1'b0, 2, 1'b0);
    send_range(0, 3);
    repeat (20) send_req(MODE_TICK, 8'($urandom));
    send_range(3, frame_q.size());
    send_req(MODE_RELEASE, 8'($urandom));
    random_traffic(req_cnt + 30, 1'b0);

    // Longest timeout: 254 ticks keep an open telegram alive
    write_timeout(8'd255);
    build_frame(1'b1, 4, 1'b0);
    send_range(0, 4);
    repeat (254) send_req(MODE_TICK, 8'($urandom));
    send_range(4, frame_q.size());
    send_req(MODE_RELEASE, 8'($urandom));
    gap_pct = 0;
    random_traffic(req_cnt + 10, 1'b0);

    // Wind down and judge
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[serial_telegram_deframer_unit] OK");
    end else begin
      $display("[serial_telegram_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
